// ----- hw/rtl/gig_pkg.sv -----
// gig_pkg: shared types and constants of the gaussian impulse gradient pipeline
// no dependencies; used by gig_quad, gig_exp, gig_grad and the top level
package gig_pkg;

    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CENTER_MU     = 2'd0,
        CFG_PRECISION_TAU = 2'd1
    } cfg_index_t;

    // kernel is Q0.16 with 1.0 representable
    localparam int          KERNEL_W   = 17;
    localparam logic [16:0] KERNEL_ONE = 17'd65536;

    // exponent at or beyond 12.0 (Q16.16) gives a zero kernel
    localparam logic [62:0] FAR_LIMIT_Q16 = 63'd786432;

    localparam int          ROM_W     = 31;
    localparam logic [61:0] Q30_ROUND = 62'd536870912;
    localparam logic [31:0] Q16_ROUND = 32'd8192;

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    // operands kept alive for the gradient stages
    typedef struct packed {
        logic [63:0] sq;
        logic [31:0] mag;
        logic        neg;
    } gig_carry_t;

    typedef struct packed {
        logic        far;
        logic [3:0]  int_part;
        logic [15:0] frac;
        gig_carry_t  carry;
    } gig_arg_t;

    typedef struct packed {
        logic [KERNEL_W-1:0] kernel;
        gig_carry_t          carry;
    } gig_kern_t;

endpackage

// ----- hw/rtl/gig_quad.sv -----
// gig_quad: offset, magnitude, square and scaled exponent argument a = tau*u*u/2
// depends on gig_pkg
module gig_quad (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  sample,
    input  logic signed [31:0]  center,
    input  logic        [31:0]  precision,
    output logic                out_valid,
    input  logic                out_ready,
    output gig_pkg::gig_arg_t   out_arg
);

    localparam int Stages = 5;

    logic [Stages-1:0] valid_reg, valid_next, stage_en;

    logic signed [32:0] u_reg, u_next;
    logic [32:0]        u_abs;
    logic [31:0]        mag1_reg, mag2_reg, mag3_reg;
    logic               neg1_reg, neg2_reg, neg3_reg;
    logic [63:0]        sq2_reg, sq2_next, sq3_reg;
    logic [63:0]        ph_reg, ph_next, pl_reg, pl_next;
    logic [63:0]        a_sum;
    logic [62:0]        a_w;
    gig_pkg::gig_arg_t  arg_reg, arg_next;

    // bubble-collapsing stage enables
    always_comb begin
        stage_en[Stages-1] = !valid_reg[Stages-1] || out_ready;
        for (int i = Stages - 2; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    assign valid_next = (valid_reg & ~stage_en) |
                        ({valid_reg[Stages-2:0], in_valid} & stage_en);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        u_next   = 33'(sample) - 33'(center);
        u_abs    = u_reg[32] ? (~unsigned'(u_reg) + 33'd1) : unsigned'(u_reg);
        sq2_next = 64'(mag1_reg) * 64'(mag1_reg);
        ph_next  = 64'(sq2_reg[63:32]) * 64'(precision);
        pl_next  = 64'(sq2_reg[31:0]) * 64'(precision);
        a_sum    = ph_reg + {32'd0, pl_reg[63:32]};
        a_w      = a_sum[63:1];

        arg_next.far       = a_w >= gig_pkg::FAR_LIMIT_Q16;
        arg_next.int_part  = a_w[19:16];
        arg_next.frac      = a_w[15:0];
        arg_next.carry.sq  = sq3_reg;
        arg_next.carry.mag = mag3_reg;
        arg_next.carry.neg = neg3_reg;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            u_reg <= u_next;
        end
        if (stage_en[1]) begin
            mag1_reg <= u_abs[31:0];
            neg1_reg <= u_reg[32];
        end
        if (stage_en[2]) begin
            sq2_reg  <= sq2_next;
            mag2_reg <= mag1_reg;
            neg2_reg <= neg1_reg;
        end
        if (stage_en[3]) begin
            ph_reg   <= ph_next;
            pl_reg   <= pl_next;
            sq3_reg  <= sq2_reg;
            mag3_reg <= mag2_reg;
            neg3_reg <= neg2_reg;
        end
        if (stage_en[4]) begin
            arg_reg <= arg_next;
        end
    end

    assign in_ready  = stage_en[0];
    assign out_valid = valid_reg[Stages-1];
    assign out_arg   = arg_reg;

endmodule

// ----- hw/rtl/gig_exp.sv -----
// gig_exp: table-based exp(-a) in Q0.16, interpolated fraction times exp(-1)^n
// depends on gig_pkg; the lookup tables are built at elaboration
module gig_exp #(
    parameter int EXP_TABLE_ENTRIES = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  gig_pkg::gig_arg_t  in_arg,
    output logic               out_valid,
    input  logic               out_ready,
    output gig_pkg::gig_kern_t out_kern
);

    localparam int Stages = 7;
    localparam int KW     = $clog2(EXP_TABLE_ENTRIES + 1);
    localparam int PW     = 16 + KW;
    localparam int RW     = gig_pkg::ROM_W;

    typedef logic [EXP_TABLE_ENTRIES:0][RW-1:0] rom_t;
    typedef logic [15:0][RW-1:0]                pow_t;

    // exp(-k/entries) in Q0.30 via truncated taylor series in Q0.50
    function automatic rom_t build_rom();
        rom_t               rom;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        rounded;
        for (int k = 0; k <= EXP_TABLE_ENTRIES; k++) begin
            term = 64'd1 << 50;
            sum  = signed'(term);
            for (int j = 1; j <= 24; j++) begin
                term = ((term * 64'(k)) / EXP_TABLE_ENTRIES) / 64'(j);
                if (j % 2 == 1) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0) begin
                sum = '0;
            end
            rounded = (unsigned'(sum) + (64'd1 << 19)) >> 20;
            rom[k]  = rounded[RW-1:0];
        end
        return rom;
    endfunction

    // exp(-1)^n by repeated rounded q30 products
    function automatic pow_t build_pow(input logic [RW-1:0] base);
        pow_t        tab;
        logic [63:0] pw;
        pw = 64'd1 << 30;
        for (int n = 0; n < 16; n++) begin
            tab[n] = pw[RW-1:0];
            pw     = (pw * 64'(base) + (64'd1 << 29)) >> 30;
        end
        return tab;
    endfunction

    localparam rom_t ExpRom = build_rom();
    localparam pow_t PowTab = build_pow(ExpRom[EXP_TABLE_ENTRIES]);

    logic [Stages-1:0] valid_reg, valid_next, stage_en;

    logic [PW-1:0]       pos;
    logic [KW-1:0]       k0_reg;
    logic [15:0]         r0_reg, r1_reg, r2_reg;
    logic [3:0]          n0_reg;
    logic                far0_reg, far1_reg, far2_reg, far3_reg, far4_reg, far5_reg;
    gig_pkg::gig_carry_t c0_reg, c1_reg, c2_reg, c3_reg, c4_reg, c5_reg;
    logic [RW-1:0]       tk1_reg, tkn1_reg, tk2_reg, tk3_reg;
    logic [RW-1:0]       pw1_reg, pw2_reg, pw3_reg, pw4_reg;
    logic [RW-1:0]       d2_reg, d2_next;
    logic [RW+15:0]      dr3_reg, dr3_next;
    logic [RW-1:0]       ef4_reg, ef4_next;
    logic [61:0]         gp5_reg, gp5_next;
    logic [61:0]         gp_rnd;
    logic [31:0]         g_rnd;
    gig_pkg::gig_kern_t  kern_reg, kern_next;

    always_comb begin
        stage_en[Stages-1] = !valid_reg[Stages-1] || out_ready;
        for (int i = Stages - 2; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    assign valid_next = (valid_reg & ~stage_en) |
                        ({valid_reg[Stages-2:0], in_valid} & stage_en);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        // table position and interpolation weight
        pos      = PW'(in_arg.frac) * PW'(EXP_TABLE_ENTRIES);
        d2_next  = tk1_reg - tkn1_reg;
        dr3_next = (RW+16)'(d2_reg) * (RW+16)'(r2_reg);
        ef4_next = tk3_reg - dr3_reg[RW+15:16];
        gp5_next = 62'(pw4_reg) * 62'(ef4_reg);
        gp_rnd   = gp5_reg + gig_pkg::Q30_ROUND;
        g_rnd    = gp_rnd[61:30] + gig_pkg::Q16_ROUND;

        kern_next.kernel = far5_reg ? '0 : g_rnd[30:14];
        kern_next.carry  = c5_reg;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            k0_reg   <= pos[PW-1:16];
            r0_reg   <= pos[15:0];
            n0_reg   <= in_arg.int_part;
            far0_reg <= in_arg.far;
            c0_reg   <= in_arg.carry;
        end
        if (stage_en[1]) begin
            tk1_reg  <= ExpRom[k0_reg];
            tkn1_reg <= ExpRom[k0_reg + KW'(1)];
            pw1_reg  <= PowTab[n0_reg];
            r1_reg   <= r0_reg;
            far1_reg <= far0_reg;
            c1_reg   <= c0_reg;
        end
        if (stage_en[2]) begin
            d2_reg   <= d2_next;
            tk2_reg  <= tk1_reg;
            r2_reg   <= r1_reg;
            pw2_reg  <= pw1_reg;
            far2_reg <= far1_reg;
            c2_reg   <= c1_reg;
        end
        if (stage_en[3]) begin
            dr3_reg  <= dr3_next;
            tk3_reg  <= tk2_reg;
            pw3_reg  <= pw2_reg;
            far3_reg <= far2_reg;
            c3_reg   <= c2_reg;
        end
        if (stage_en[4]) begin
            ef4_reg  <= ef4_next;
            pw4_reg  <= pw3_reg;
            far4_reg <= far3_reg;
            c4_reg   <= c3_reg;
        end
        if (stage_en[5]) begin
            gp5_reg  <= gp5_next;
            far5_reg <= far4_reg;
            c5_reg   <= c4_reg;
        end
        if (stage_en[6]) begin
            kern_reg <= kern_next;
        end
    end

    assign in_ready  = stage_en[0];
    assign out_valid = valid_reg[Stages-1];
    assign out_kern  = kern_reg;

endmodule

// ----- hw/rtl/gig_grad.sv -----
// gig_grad: gradients G*tau*u and -u*u*G/2 with saturation, output register
// depends on gig_pkg
module gig_grad (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  gig_pkg::gig_kern_t in_kern,
    input  logic        [31:0] precision,
    output logic               out_valid,
    input  logic               out_ready,
    output logic        [16:0] kernel_value,
    output logic signed [31:0] grad_center,
    output logic signed [31:0] grad_precision,
    output logic               clipped
);

    localparam int Stages = 4;
    localparam int KW     = gig_pkg::KERNEL_W;

    logic [Stages-1:0] valid_reg, valid_next, stage_en;

    logic [48:0]   gt0_reg, gt0_next, th0_reg, th0_next, tl0_reg, tl0_next;
    logic [31:0]   mag0_reg;
    logic          neg0_reg, neg1_reg, neg2_reg;
    logic [KW-1:0] g0_reg, g1_reg, g2_reg;
    logic [48:0]   mh1_reg, mh1_next;
    logic [63:0]   ml1_reg, ml1_next;
    logic [49:0]   tsum;
    logic [48:0]   mtau1_reg, mtau2_reg;
    logic [49:0]   mmu2_reg, mmu2_next;
    logic          clip_mu, clip_tau;
    logic [31:0]   mu_mag, tau_mag;
    logic [KW-1:0] kern_reg;
    logic [31:0]   gmu_reg, gmu_next, gtau_reg, gtau_next;
    logic          clip_reg;

    always_comb begin
        stage_en[Stages-1] = !valid_reg[Stages-1] || out_ready;
        for (int i = Stages - 2; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    assign valid_next = (valid_reg & ~stage_en) |
                        ({valid_reg[Stages-2:0], in_valid} & stage_en);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        gt0_next  = 49'(in_kern.kernel) * 49'(precision);
        th0_next  = 49'(in_kern.carry.sq[63:32]) * 49'(in_kern.kernel);
        tl0_next  = 49'(in_kern.carry.sq[31:0]) * 49'(in_kern.kernel);
        // g*tau*m split into upper and lower halves of g*tau
        mh1_next  = 49'(gt0_reg[48:32]) * 49'(mag0_reg);
        ml1_next  = 64'(gt0_reg[31:0]) * 64'(mag0_reg);
        tsum      = 50'(th0_reg) + 50'(tl0_reg[48:32]);
        mmu2_next = 50'(mh1_reg) + 50'(ml1_reg[63:32]);

        if (neg2_reg) begin
            clip_mu = mmu2_reg > 50'(gig_pkg::SAT_NEG);
            mu_mag  = clip_mu ? gig_pkg::SAT_NEG : mmu2_reg[31:0];
            gmu_next = ~mu_mag + 32'd1;
        end else begin
            clip_mu = mmu2_reg > 50'(gig_pkg::SAT_POS);
            mu_mag  = clip_mu ? gig_pkg::SAT_POS : mmu2_reg[31:0];
            gmu_next = mu_mag;
        end
        clip_tau  = mtau2_reg > 49'(gig_pkg::SAT_NEG);
        tau_mag   = clip_tau ? gig_pkg::SAT_NEG : mtau2_reg[31:0];
        gtau_next = ~tau_mag + 32'd1;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            gt0_reg  <= gt0_next;
            th0_reg  <= th0_next;
            tl0_reg  <= tl0_next;
            mag0_reg <= in_kern.carry.mag;
            neg0_reg <= in_kern.carry.neg;
            g0_reg   <= in_kern.kernel;
        end
        if (stage_en[1]) begin
            mh1_reg   <= mh1_next;
            ml1_reg   <= ml1_next;
            mtau1_reg <= tsum[49:1];
            neg1_reg  <= neg0_reg;
            g1_reg    <= g0_reg;
        end
        if (stage_en[2]) begin
            mmu2_reg  <= mmu2_next;
            mtau2_reg <= mtau1_reg;
            neg2_reg  <= neg1_reg;
            g2_reg    <= g1_reg;
        end
        if (stage_en[3]) begin
            kern_reg <= g2_reg;
            gmu_reg  <= gmu_next;
            gtau_reg <= gtau_next;
            clip_reg <= clip_mu || clip_tau;
        end
    end

    assign in_ready       = stage_en[0];
    assign out_valid      = valid_reg[Stages-1];
    assign kernel_value   = kern_reg;
    assign grad_center    = $signed(gmu_reg);
    assign grad_precision = $signed(gtau_reg);
    assign clipped        = clip_reg;

endmodule

// ----- hw/rtl/gaussian_impulse_gradient.sv -----
// gaussian_impulse_gradient: top level, configuration registers and pipeline chain
// depends on gig_pkg, gig_quad, gig_exp and gig_grad
//
// Streams Q16.16 samples x and returns, per beat, the Gaussian kernel
// G = exp(-tau*(x-mu)^2/2) as unsigned Q0.16 together with the saturating
// Q16.16 gradients by mu and by tau and a flag that either one clipped.
// One beat is accepted every clock cycle unless a stall at m_ready has filled
// the chain; a result passes through the 16 register stages of the chain
// (5 for the square and exponent argument, 7 for the exponential lookup and
// power product, 4 for the gradient products and saturation), the first of
// which loads at the edge that takes its sample. Stalls at m_ready back up
// stage by stage, so empty stages keep taking samples while a result waits.
// center_mu is config index 0 and precision_tau index 1; a write of zero to
// precision_tau is dropped. Write the registers only while the pipeline is empty.
module gaussian_impulse_gradient #(
    parameter int EXP_TABLE_ENTRIES = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [31:0]              s_sample_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic        [16:0]              m_kernel_value,
    output logic signed [31:0]              m_grad_center,
    output logic signed [31:0]              m_grad_precision,
    output logic                            m_clipped,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gig_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data
);

    logic [31:0] mu_reg, mu_next, tau_reg, tau_next;

    logic               quad_valid, quad_ready;
    gig_pkg::gig_arg_t  quad_arg;
    logic               exp_valid, exp_ready;
    gig_pkg::gig_kern_t exp_kern;

    assign cfg_ready = 1'b1;

    always_comb begin
        mu_next  = mu_reg;
        tau_next = tau_reg;
        if (cfg_valid) begin
            case (cfg_index)
                gig_pkg::CFG_CENTER_MU: begin
                    mu_next = cfg_data;
                end
                gig_pkg::CFG_PRECISION_TAU: begin
                    // precision must stay positive
                    if (cfg_data != '0) begin
                        tau_next = cfg_data;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu_reg  <= '0;
            tau_reg <= 32'd65536;
        end else begin
            mu_reg  <= mu_next;
            tau_reg <= tau_next;
        end
    end

    gig_quad u_quad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .sample    (s_sample_value),
        .center    ($signed(mu_reg)),
        .precision (tau_reg),
        .out_valid (quad_valid),
        .out_ready (quad_ready),
        .out_arg   (quad_arg)
    );

    gig_exp #(
        .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
    ) u_exp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (quad_valid),
        .in_ready  (quad_ready),
        .in_arg    (quad_arg),
        .out_valid (exp_valid),
        .out_ready (exp_ready),
        .out_kern  (exp_kern)
    );

    gig_grad u_grad (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (exp_valid),
        .in_ready       (exp_ready),
        .in_kern        (exp_kern),
        .precision      (tau_reg),
        .out_valid      (m_valid),
        .out_ready      (m_ready),
        .kernel_value   (m_kernel_value),
        .grad_center    (m_grad_center),
        .grad_precision (m_grad_precision),
        .clipped        (m_clipped)
    );

    a_kernel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_kernel_value <= gig_pkg::KERNEL_ONE)
        else $error("kernel value above one");

    a_tau_grad_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_grad_precision == 32'sd0 || m_grad_precision[31]))
        else $error("precision gradient positive");

    a_zero_kernel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kernel_value == 17'd0) |->
            (m_grad_center == 32'sd0 && m_grad_precision == 32'sd0 && !m_clipped))
        else $error("nonzero gradient with zero kernel");

    a_tau_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        tau_reg != 32'd0)
        else $error("precision register reached zero");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without output backpressure");

endmodule
